### sv/iaisr_pkg.sv
// Package for the indexed array block: operation and status codes,
// controller command and datapath status types.
// No dependencies; used by every module of the block.
`default_nettype none

package iaisr_pkg;

  // Default number of entries in the array.
  localparam int unsigned DEPTH_DEF = 32;

  // Operation codes carried by an input item.
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_INSERT = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_SEARCH = 3'd5;

  // Status codes returned with a result item.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;

  // Memory write address source.
  typedef enum logic [1:0] {
    WA_COUNT,
    WA_POS,
    WA_IDX
  } wa_sel_e;

  // Memory write data source.
  typedef enum logic {
    WD_WORD,
    WD_RDATA
  } wd_sel_e;

  // Memory read address source.
  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_M1,
    RA_IDX_P1
  } ra_sel_e;

  // Loop index update.
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_COUNT,
    IDX_POS,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_e;

  // Count and capacity update.
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_LOAD,
    CNT_INC,
    CNT_DEC
  } cnt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch;
    logic    mem_we;
    wa_sel_e wa_sel;
    wd_sel_e wd_sel;
    ra_sel_e ra_sel;
    idx_op_e idx_op;
    cnt_op_e cnt_op;
    logic    res_we;
    logic    [1:0] res_status;
    logic    res_found;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       cnt_zero;
    logic       cnt_full;
    logic       pos_lt_cnt;
    logic       pos_le_cnt;
    logic       cnt_lt_cap;
    logic       idx_gt_pos1;
    logic       idx_p1_lt_cnt;
    logic       idx_lt_cnt;
    logic       hit;
  } sts_t;

endpackage

`default_nettype wire

### sv/indexed_array_insert_remove_search_top.sv
// Clear, load, update, insert at the end and rejected items need no loop. Insert shifts the
// entries from the position up by one; remove shifts the entries above the position down by
// one; search compares entries from index zero until the first hit, or all of them on a miss.
// Each shift or compare step is a registered memory read, then the write or compare.
// One item at a time: a new item is taken the cycle after its result enters the output
// register. Reset clears count and capacity; entries hold no reset value.
`default_nettype none

module indexed_array_insert_remove_search_top
  import iaisr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic [7:0]         found_index_o,
  output logic [8:0]         used_count_o
);

  cmd_t cmd;
  sts_t sts;

  // Operation sequencer.
  iaisr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Entry storage and arithmetic.
  iaisr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .word_i        (word_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .used_count_o  (used_count_o)
  );

endmodule

`default_nettype wire

### sv/iaisr_dp.sv
// Datapath of the indexed array block: entry memory, count, capacity,
// loop index, item and result registers. Depends on iaisr_pkg.
`default_nettype none

module iaisr_dp
  import iaisr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] word_i,
  output logic [1:0]         status_o,
  output logic [7:0]         found_index_o,
  output logic [8:0]         used_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_q;

  logic [2:0]    op_q;
  logic [7:0]    pos_q;
  logic [31:0]   word_q;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [CW-1:0] idx_q, idx_d;

  logic [1:0]    res_status_q;
  logic [7:0]    res_found_q;
  logic [1:0]    status_q;
  logic [7:0]    found_q;
  logic [8:0]    used_q;

  logic [8:0]    pos9, cnt9, cap9, idx9;
  logic [CW-1:0] cnt_p1, idx_p1, idx_m1;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata;

  // Widened copies for comparisons.
  assign pos9   = {1'b0, pos_q};
  assign cnt9   = 9'(count_q);
  assign cap9   = 9'(cap_q);
  assign idx9   = 9'(idx_q);
  assign cnt_p1 = count_q + CW'(1);
  assign idx_p1 = idx_q + CW'(1);
  assign idx_m1 = idx_q - CW'(1);

  // Status flags for the controller.
  always_comb begin
    sts_o.op            = op_q;
    sts_o.cnt_zero      = (count_q == '0);
    sts_o.cnt_full      = (cnt9 == 9'(DEPTH));
    sts_o.pos_lt_cnt    = (pos9 < cnt9);
    sts_o.pos_le_cnt    = (pos9 <= cnt9);
    sts_o.cnt_lt_cap    = (cnt9 < cap9);
    sts_o.idx_gt_pos1   = (idx9 > (pos9 + 9'd1));
    sts_o.idx_p1_lt_cnt = ((idx9 + 9'd1) < cnt9);
    sts_o.idx_lt_cnt    = (idx9 < cnt9);
    sts_o.hit           = (rdata_q == word_q);
  end

  // Item registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= operation_i;
      pos_q  <= position_i;
      word_q <= word_i;
    end
  end

  // Memory address and data selection.
  always_comb begin
    unique case (cmd_i.wa_sel)
      WA_COUNT: waddr = count_q[AW-1:0];
      WA_POS:   waddr = pos9[AW-1:0];
      WA_IDX:   waddr = idx_q[AW-1:0];
      default:  waddr = idx_q[AW-1:0];
    endcase
    unique case (cmd_i.wd_sel)
      WD_WORD:  wdata = word_q;
      WD_RDATA: wdata = rdata_q;
      default:  wdata = word_q;
    endcase
    unique case (cmd_i.ra_sel)
      RA_IDX:    raddr = idx_q[AW-1:0];
      RA_IDX_M1: raddr = idx_m1[AW-1:0];
      RA_IDX_P1: raddr = idx_p1[AW-1:0];
      default:   raddr = idx_q[AW-1:0];
    endcase
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Next count, capacity and loop index.
  always_comb begin
    count_d = count_q;
    cap_d   = cap_q;
    unique case (cmd_i.cnt_op)
      CNT_HOLD: ;
      CNT_CLEAR: begin
        count_d = '0;
        cap_d   = '0;
      end
      CNT_LOAD: begin
        count_d = cnt_p1;
        if (cap_q < cnt_p1) begin
          cap_d = cnt_p1;
        end
      end
      CNT_INC: count_d = cnt_p1;
      CNT_DEC: count_d = count_q - CW'(1);
      default: ;
    endcase
    unique case (cmd_i.idx_op)
      IDX_HOLD:  idx_d = idx_q;
      IDX_COUNT: idx_d = count_q;
      IDX_POS:   idx_d = pos9[CW-1:0];
      IDX_ZERO:  idx_d = '0;
      IDX_INC:   idx_d = idx_p1;
      IDX_DEC:   idx_d = idx_m1;
      default:   idx_d = idx_q;
    endcase
  end

  // Count and capacity registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= '0;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  // Loop index register.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
  end

  // Result and output registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_we) begin
      res_status_q <= cmd_i.res_status;
      res_found_q  <= cmd_i.res_found ? 8'(idx_q) : 8'd0;
    end
    if (cmd_i.out_load) begin
      status_q <= res_status_q;
      found_q  <= res_found_q;
      used_q   <= cnt9;
    end
  end

  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign used_count_o  = used_q;

endmodule

`default_nettype wire

### sv/iaisr_ctrl.sv
// Controller of the indexed array block: sequences each operation over
// the datapath and runs the input and output handshakes. Depends on iaisr_pkg.
`default_nettype none

module iaisr_ctrl
  import iaisr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_EXEC    = 4'd1;
  localparam logic [3:0] S_INS_RD  = 4'd2;
  localparam logic [3:0] S_INS_WR  = 4'd3;
  localparam logic [3:0] S_INS_PUT = 4'd4;
  localparam logic [3:0] S_RM_RD   = 4'd5;
  localparam logic [3:0] S_RM_WR   = 4'd6;
  localparam logic [3:0] S_SR_RD   = 4'd7;
  localparam logic [3:0] S_SR_CMP  = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        // Unless a loop starts below, the item finishes here.
        state_d          = S_DONE;
        cmd_o.res_we     = 1'b1;
        cmd_o.res_status = ST_REJECT;
        unique case (sts_i.op)
          OP_CLEAR: begin
            cmd_o.cnt_op     = CNT_CLEAR;
            cmd_o.res_status = ST_DONE;
          end
          OP_LOAD: begin
            if (!sts_i.cnt_full) begin
              cmd_o.mem_we     = 1'b1;
              cmd_o.wa_sel     = WA_COUNT;
              cmd_o.wd_sel     = WD_WORD;
              cmd_o.cnt_op     = CNT_LOAD;
              cmd_o.res_status = ST_DONE;
            end
          end
          OP_UPDATE: begin
            if (!sts_i.cnt_zero && sts_i.pos_lt_cnt) begin
              cmd_o.mem_we     = 1'b1;
              cmd_o.wa_sel     = WA_POS;
              cmd_o.wd_sel     = WD_WORD;
              cmd_o.res_status = ST_DONE;
            end
          end
          OP_INSERT: begin
            if (!sts_i.cnt_zero && sts_i.cnt_lt_cap && !sts_i.cnt_full &&
                sts_i.pos_le_cnt) begin
              if (sts_i.pos_lt_cnt) begin
                cmd_o.res_we = 1'b0;
                cmd_o.idx_op = IDX_COUNT;
                state_d      = S_INS_RD;
              end else begin
                // Appending at the end needs no shift.
                cmd_o.mem_we     = 1'b1;
                cmd_o.wa_sel     = WA_POS;
                cmd_o.wd_sel     = WD_WORD;
                cmd_o.cnt_op     = CNT_INC;
                cmd_o.res_status = ST_DONE;
              end
            end
          end
          OP_REMOVE: begin
            if (!sts_i.cnt_zero && sts_i.pos_lt_cnt) begin
              cmd_o.res_we = 1'b0;
              cmd_o.idx_op = IDX_POS;
              state_d      = S_RM_RD;
            end
          end
          OP_SEARCH: begin
            if (!sts_i.cnt_zero) begin
              cmd_o.res_we = 1'b0;
              cmd_o.idx_op = IDX_ZERO;
              state_d      = S_SR_RD;
            end
          end
          default: ;
        endcase
      end
      // Shift the tail up one entry at a time, from the top down.
      S_INS_RD: begin
        cmd_o.ra_sel = RA_IDX_M1;
        state_d      = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wa_sel = WA_IDX;
        cmd_o.wd_sel = WD_RDATA;
        cmd_o.idx_op = IDX_DEC;
        state_d      = sts_i.idx_gt_pos1 ? S_INS_RD : S_INS_PUT;
      end
      S_INS_PUT: begin
        cmd_o.mem_we     = 1'b1;
        cmd_o.wa_sel     = WA_POS;
        cmd_o.wd_sel     = WD_WORD;
        cmd_o.cnt_op     = CNT_INC;
        cmd_o.res_we     = 1'b1;
        cmd_o.res_status = ST_DONE;
        state_d          = S_DONE;
      end
      // Shift the tail down one entry at a time, from the position up.
      S_RM_RD: begin
        if (sts_i.idx_p1_lt_cnt) begin
          cmd_o.ra_sel = RA_IDX_P1;
          state_d      = S_RM_WR;
        end else begin
          cmd_o.cnt_op     = CNT_DEC;
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_DONE;
          state_d          = S_DONE;
        end
      end
      S_RM_WR: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wa_sel = WA_IDX;
        cmd_o.wd_sel = WD_RDATA;
        cmd_o.idx_op = IDX_INC;
        state_d      = S_RM_RD;
      end
      // Linear search from entry zero; the first hit wins.
      S_SR_RD: begin
        if (sts_i.idx_lt_cnt) begin
          cmd_o.ra_sel = RA_IDX;
          state_d      = S_SR_CMP;
        end else begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_MISS;
          state_d          = S_DONE;
        end
      end
      S_SR_CMP: begin
        if (sts_i.hit) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_DONE;
          cmd_o.res_found  = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.idx_op = IDX_INC;
          state_d      = S_SR_RD;
        end
      end
      // Hand the result to the output register once it is free.
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on a load, cleared when the item is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### sv/iaisr_chk.sv
// Port-level checks for the indexed array block, bound to the top level.
// Depends on iaisr_pkg and indexed_array_insert_remove_search_top.
`default_nettype none

module iaisr_chk
  import iaisr_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         status_o,
  input logic [7:0]         found_index_o,
  input logic [8:0]         used_count_o
);

  // Each item is worked alone, so an accepted item blocks the next cycle.
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // A stalled result item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(found_index_o) && $stable(used_count_o))
    else $error("stalled result item changed");

  // Only defined status codes appear, and an index only with a hit.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE || status_o == ST_REJECT ||
      status_o == ST_MISS) && (status_o == ST_DONE || found_index_o == 8'd0))
    else $error("bad status or stray found index");

  // The used count never passes the depth, and a hit lies below it.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> used_count_o <= 9'(DEPTH) &&
      (found_index_o == 8'd0 || 9'(found_index_o) < used_count_o))
    else $error("used count or found index out of range");

endmodule

bind indexed_array_insert_remove_search_top iaisr_chk #(
  .DEPTH (DEPTH)
) u_iaisr_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .found_index_o (found_index_o),
  .used_count_o  (used_count_o)
);

`default_nettype wire

### verif/indexed_array_insert_remove_search_top_tb.sv
// Self-checking testbench for the indexed array block: directed and random items
// through a queue-fed driver, with results checked against an in-bench array predictor.
// Depends on iaisr_pkg and indexed_array_insert_remove_search_top.
`timescale 1ns / 1ps

module indexed_array_insert_remove_search_top_tb;
  import iaisr_pkg::*;

  localparam int unsigned SLOTS        = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned PHASE_ITEMS  = 60;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE       = 2 * SLOTS + 40;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // One pending item with the idling pattern that goes with it.
  typedef struct {
    logic [2:0]         op;
    logic [7:0]         pos;
    logic signed [31:0] word;
    bit                 drain;
    int unsigned        snd_pct;
    int unsigned        rcv_pct;
  } array_cmd_t;

  // The three fields of one result item.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] found;
    logic [8:0] used;
  } outcome_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [2:0]         operation_i = OP_CLEAR;
  logic [7:0]         position_i  = '0;
  logic signed [31:0] word_i      = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic [7:0]         found_index_o;
  logic [8:0]         used_count_o;

  array_cmd_t  cmd_q[$];
  outcome_t    outcome_q[$];

  // Predicted contents of the array.
  logic signed [31:0] slot_word [SLOTS];
  int unsigned        used_slots = 0;
  int unsigned        slot_limit = 0;

  // Count and capacity as the generator expects them, used to aim positions.
  int unsigned        plan_count = 0;
  int unsigned        plan_cap   = 0;
  logic signed [31:0] word_pool[$];
  int unsigned        gen_mode   = 0;
  bit                 drain_next = 1'b0;
  int unsigned        n_queued   = 0;

  int unsigned snd_pct     = 0;
  int unsigned rcv_pct     = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_checked   = 0;
  int unsigned hold_left   = 0;
  bit          hold_done   = 1'b0;
  int unsigned cycles      = 0;
  int unsigned mismatches  = 0;
  int unsigned n_done      = 0;
  int unsigned n_rejected  = 0;
  int unsigned n_missed    = 0;
  int unsigned n_searched  = 0;

  indexed_array_insert_remove_search_top #(
    .DEPTH(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .position_i    (position_i),
    .word_i        (word_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .used_count_o  (used_count_o)
  );

  // Clock and a single reset at the start.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;
  end

  // Applies one operation to the predicted array and returns its result.
  function automatic outcome_t apply_array_op(logic [2:0] op, logic [7:0] pos,
                                              logic signed [31:0] w);
    outcome_t    r;
    int unsigned p;
    int          i;
    bit          hit;
    r.status = ST_REJECT;
    r.found  = '0;
    p        = pos;
    hit      = 1'b0;
    case (op)
      OP_CLEAR: begin
        used_slots = 0;
        slot_limit = 0;
        r.status   = ST_DONE;
      end
      OP_LOAD: begin
        if (used_slots < SLOTS) begin
          slot_word[used_slots] = w;
          used_slots++;
          if (slot_limit < used_slots) slot_limit = used_slots;
          r.status = ST_DONE;
        end
      end
      OP_UPDATE: begin
        if (p < used_slots) begin
          slot_word[p] = w;
          r.status     = ST_DONE;
        end
      end
      OP_INSERT: begin
        if (used_slots != 0 && used_slots < slot_limit && used_slots < SLOTS &&
            p <= used_slots) begin
          for (i = used_slots; i > int'(p); i--) slot_word[i] = slot_word[i - 1];
          slot_word[p] = w;
          used_slots++;
          r.status = ST_DONE;
        end
      end
      OP_REMOVE: begin
        if (p < used_slots) begin
          for (i = p; i + 1 < int'(used_slots); i++) slot_word[i] = slot_word[i + 1];
          slot_word[used_slots - 1] = '0;
          used_slots--;
          r.status = ST_DONE;
        end
      end
      OP_SEARCH: begin
        if (used_slots != 0) begin
          r.status = ST_MISS;
          for (i = 0; i < int'(used_slots); i++) begin
            if (!hit && slot_word[i] == w) begin
              hit      = 1'b1;
              r.status = ST_DONE;
              r.found  = 8'(i);
            end
          end
        end
      end
      default: ;
    endcase
    r.used = 9'(used_slots);
    return r;
  endfunction

  // Mostly extremes and small values, so that duplicates and sign edges show up.
  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  // A position below limit most of the time, anywhere in the field otherwise.
  function automatic logic [7:0] pick_pos(int unsigned limit);
    if (limit == 0 || $urandom_range(99) < 15) return 8'($urandom_range(255));
    return 8'($urandom_range(limit - 1));
  endfunction

  function automatic logic signed [31:0] pick_search_word();
    if (word_pool.size() != 0 && $urandom_range(9) < 7)
      return word_pool[$urandom_range(word_pool.size() - 1)];
    return pick_word();
  endfunction

  // Queues one item and tracks the count so later positions can be aimed.
  task automatic push_cmd(logic [2:0] op, logic [7:0] pos, logic signed [31:0] w);
    array_cmd_t c;
    c.op    = op;
    c.pos   = pos;
    c.word  = w;
    c.drain = drain_next;
    case (gen_mode)
      1:       begin c.snd_pct = 56; c.rcv_pct = 0;  end
      2:       begin c.snd_pct = 0;  c.rcv_pct = 56; end
      3:       begin c.snd_pct = 23; c.rcv_pct = 23; end
      default: begin c.snd_pct = 0;  c.rcv_pct = 0;  end
    endcase
    drain_next = 1'b0;
    cmd_q.insert(cmd_q.size(), c);
    n_queued++;
    case (op)
      OP_CLEAR: begin
        plan_count = 0;
        plan_cap   = 0;
        word_pool.delete();
      end
      OP_LOAD: begin
        if (plan_count < SLOTS) begin
          plan_count++;
          if (plan_cap < plan_count) plan_cap = plan_count;
          word_pool.insert(word_pool.size(), w);
        end
      end
      OP_UPDATE: begin
        if (pos < plan_count) word_pool.insert(word_pool.size(), w);
      end
      OP_INSERT: begin
        if (plan_count != 0 && plan_count < plan_cap && pos <= plan_count) begin
          plan_count++;
          word_pool.insert(word_pool.size(), w);
        end
      end
      OP_REMOVE: begin
        if (pos < plan_count) plan_count--;
      end
      default: ;
    endcase
    if (word_pool.size() > 40) void'(word_pool.pop_front());
  endtask

  // Stimulus: directed corner cases, then random set-up and edit sequences.
  initial begin : stim_proc
    int unsigned n_directed;
    int unsigned n_load;
    int unsigned n_body;
    int unsigned seq;
    int unsigned last_mode;
    int unsigned r;
    int unsigned k;

    // Everything on an empty array is rejected; unknown codes are rejected as well.
    push_cmd(OP_SEARCH, 8'd0, 32'sd0);
    push_cmd(OP_UPDATE, 8'd0, 32'sd1);
    push_cmd(OP_INSERT, 8'd0, 32'sd1);
    push_cmd(OP_REMOVE, 8'd0, 32'sd0);
    push_cmd(3'd6, 8'd255, 32'sh7FFF_FFFF);
    push_cmd(3'd7, 8'd0, 32'sh8000_0000);
    // Set up four words at the sign extremes; capacity follows the loads.
    push_cmd(OP_LOAD, 8'd255, -32'sd1);
    push_cmd(OP_LOAD, 8'd0, 32'sh8000_0000);
    push_cmd(OP_LOAD, 8'd0, 32'sh7FFF_FFFF);
    push_cmd(OP_LOAD, 8'd0, 32'sd0);
    // Insert with the count at the capacity is rejected.
    push_cmd(OP_INSERT, 8'd0, 32'sd9);
    push_cmd(OP_SEARCH, 8'd0, 32'sh7FFF_FFFF);
    push_cmd(OP_SEARCH, 8'd0, 32'sd5);
    // Positions at and beyond the count.
    push_cmd(OP_UPDATE, 8'd4, 32'sd5);
    push_cmd(OP_UPDATE, 8'd255, 32'sd5);
    push_cmd(OP_UPDATE, 8'd3, 32'sd5);
    push_cmd(OP_REMOVE, 8'd4, 32'sd0);
    push_cmd(OP_REMOVE, 8'd0, 32'sd0);
    push_cmd(OP_INSERT, 8'd4, 32'sd0);
    // Insert at the end, then search for a word held twice.
    push_cmd(OP_INSERT, 8'd3, 32'sh7FFF_FFFF);
    push_cmd(OP_SEARCH, 8'd0, 32'sh7FFF_FFFF);
    push_cmd(OP_REMOVE, 8'd3, 32'sd0);
    push_cmd(OP_INSERT, 8'd0, 32'sd1);
    push_cmd(OP_CLEAR, 8'd255, -32'sd1);
    push_cmd(OP_SEARCH, 8'd0, 32'sd1);
    n_directed = n_queued;

    seq       = 0;
    last_mode = 0;
    while (n_queued - n_directed < RANDOM_ITEMS) begin
      gen_mode = ((n_queued - n_directed) / PHASE_ITEMS) % 4;
      if (gen_mode != last_mode) drain_next = 1'b1;
      last_mode = gen_mode;
      if (seq != 0 && $urandom_range(9) == 0) begin
        // A burst of unstructured items.
        n_body = $urandom_range(1, 4);
        for (k = 0; k < n_body; k++)
          push_cmd(3'($urandom_range(7)), 8'($urandom_range(255)), $urandom);
      end else begin
        if (seq == 0 || $urandom_range(4) != 0)
          push_cmd(OP_CLEAR, 8'($urandom_range(255)), $urandom);
        // The first sequence fills the array and loads past the end.
        if (seq == 0) n_load = SLOTS + 2;
        else if ($urandom_range(7) == 0) n_load = $urandom_range(SLOTS - 4, SLOTS + 2);
        else n_load = $urandom_range(1, 8);
        for (k = 0; k < n_load; k++)
          push_cmd(OP_LOAD, 8'($urandom_range(255)), pick_word());
        n_body = $urandom_range(6, 30);
        for (k = 0; k < n_body; k++) begin
          r = $urandom_range(99);
          if (r < 20)      push_cmd(OP_UPDATE, pick_pos(plan_count), pick_word());
          else if (r < 45) push_cmd(OP_INSERT, pick_pos(plan_count + 1), pick_word());
          else if (r < 70) push_cmd(OP_REMOVE, pick_pos(plan_count), pick_word());
          else if (r < 93) push_cmd(OP_SEARCH, 8'($urandom_range(255)), pick_search_word());
          else             push_cmd(OP_LOAD, 8'($urandom_range(255)), pick_word());
        end
      end
      seq++;
    end

    // Let everything drain, then allow for a late spurious result.
    while (cmd_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    mismatches += outcome_q.size();

    $display("Checked %0d items in %0d sequences: %0d done, %0d rejected,",
             n_checked, seq, n_done, n_rejected);
    $display("%0d searches (%0d missed).", n_searched, n_missed);
    $display("Idling patterns covered: none, sender only, receiver only, both; plus a long output hold.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: offers queued items, holds a stalled item, predicts accepted ones.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    array_cmd_t nxt;
    bit         taken;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      operation_i <= OP_CLEAR;
      position_i  <= '0;
      word_i      <= '0;
      snd_pct     <= 0;
      rcv_pct     <= 0;
      n_accepted  <= 0;
    end else begin
      taken = in_valid_i && !in_stall_o;
      if (taken) begin
        outcome_q.insert(outcome_q.size(), apply_array_op(operation_i, position_i, word_i));
        n_accepted <= n_accepted + 1;
      end
      if (in_valid_i && !taken) begin
        // Stalled: the item stays on the inputs as it is.
      end else if (cmd_q.size() != 0 &&
                   !(cmd_q[0].drain && (taken || n_checked != n_accepted)) &&
                   $urandom_range(99) >= snd_pct) begin
        nxt = cmd_q.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= nxt.op;
        position_i  <= nxt.pos;
        word_i      <= nxt.word;
        snd_pct     <= nxt.snd_pct;
        rcv_pct     <= nxt.rcv_pct;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // One long output hold once the run is well under way.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  function automatic void flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("cycle %0d: %s", cycles, msg);
  endfunction

  // Monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    outcome_t want;
    outcome_t got;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      n_checked   <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        n_checked <= n_checked + 1;
        got = {status_o, found_index_o, used_count_o};
        if (outcome_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: status %0d index %0d count %0d",
                                  got.status, got.found, got.used));
        end else begin
          want = outcome_q.pop_front();
          if (got !== want)
            flag_mismatch($sformatf({"expected status %0d index %0d count %0d, ",
                                     "got status %0d index %0d count %0d"},
                                    want.status, want.found, want.used,
                                    got.status, got.found, got.used));
          if (want.status == ST_REJECT) n_rejected++;
          else n_done++;
          if (want.status == ST_MISS) n_missed++;
        end
      end
      if (in_valid_i && !in_stall_o && operation_i == OP_SEARCH) n_searched++;
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < rcv_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, outcome_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

endmodule

### indexed_array_insert_remove_search_top.f
sv/iaisr_pkg.sv
sv/iaisr_dp.sv
sv/iaisr_ctrl.sv
sv/indexed_array_insert_remove_search_top.sv
sv/iaisr_chk.sv
verif/indexed_array_insert_remove_search_top_tb.sv
